@@ design/bd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bd_pkg
// Types, codes and helpers shared by the bounded deque modules.
// ----------------------------------------------------------------------------
package bd_pkg;

	localparam int DEPTH   = 16;
	localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int SUM_W   = $clog2(2 * DEPTH);
	localparam int DATA_W  = 32;
	localparam int OP_W    = 3;
	localparam int STAT_W  = 2;
	localparam int ITEM_W  = 5;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]          opcode;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] back_value;
		logic [ITEM_W-1:0]        item_count;
		logic                     is_empty;
	} res_t;

	typedef struct packed {
		logic apply;
		logic read;
	} dp_ctrl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SEND
	} state_t;

	function automatic logic [PTR_W-1:0] wrap_slot(input logic [SUM_W-1:0] pos);
		logic [SUM_W-1:0] adj;
		adj = (pos >= SUM_W'(DEPTH)) ? pos - SUM_W'(DEPTH) : pos;
		return adj[PTR_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ design/bd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bd_ctrl
// Sequencer for one operation: update, store read, result beat.
// ----------------------------------------------------------------------------
module bd_ctrl
	import bd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cmd_valid,
	output logic          cmd_stall,
	output logic          res_valid,
	input  wire logic     res_stall,
	output dp_ctrl_t      ctrl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) state_d = S_READ;
			end
			S_READ: begin
				state_d = S_SEND;
			end
			S_SEND: begin
				if (!res_stall) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_stall  = 1'b1;
		res_valid  = 1'b0;
		ctrl.apply = 1'b0;
		ctrl.read  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd_stall  = 1'b0;
				ctrl.apply = cmd_valid;
			end
			S_READ: begin
				ctrl.read = 1'b1;
			end
			S_SEND: begin
				res_valid = 1'b1;
			end
			default: begin
				cmd_stall = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ design/bd_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bd_datapath
// Circular store with head pointer, occupancy count and result registers.
// ----------------------------------------------------------------------------
module bd_datapath
	import bd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire dp_ctrl_t ctrl,
	input  wire cmd_t     cmd,
	output res_t          res
);

	logic [DATA_W-1:0] mem [DEPTH];

	logic [PTR_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [STAT_W-1:0] status_q;
	logic [DATA_W-1:0] front_q;
	logic [DATA_W-1:0] back_q;

	logic [PTR_W-1:0]  head_d;
	logic [CNT_W-1:0]  count_d;
	logic [STAT_W-1:0] status_d;
	logic              full;
	logic              empty;
	logic              we;
	logic [PTR_W-1:0]  waddr;
	logic [PTR_W-1:0]  head_dec;
	logic [PTR_W-1:0]  head_inc;
	logic [PTR_W-1:0]  tail;
	logic [PTR_W-1:0]  back_addr;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign head_dec = (head_q == '0) ? PTR_W'(DEPTH - 1) : head_q - 1'b1;
	assign head_inc = wrap_slot(SUM_W'(head_q) + SUM_W'(1));
	assign tail     = wrap_slot(SUM_W'(head_q) + SUM_W'(count_q));
	assign back_addr = wrap_slot(SUM_W'(head_q) + SUM_W'(count_q) - SUM_W'(1));

	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		status_d = ST_DONE;
		we       = 1'b0;
		waddr    = tail;
		unique case (cmd.opcode) inside
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					we      = 1'b1;
					count_d = count_q + 1'b1;
					if (cmd.opcode == OP_PUSH_FRONT) begin
						head_d = head_dec;
						waddr  = head_dec;
					end
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					count_d = count_q - 1'b1;
					if (cmd.opcode == OP_POP_FRONT) head_d = head_inc;
				end
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			status_q <= ST_DONE;
		end else if (ctrl.apply) begin
			head_q   <= head_d;
			count_q  <= count_d;
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.apply && we) mem[waddr] <= cmd.value;
	end

	always_ff @(posedge clk) begin
		if (ctrl.read) begin
			front_q <= mem[head_q];
			back_q  <= mem[back_addr];
		end
	end

	// empty deque reports zero ends
	assign res.status      = status_q;
	assign res.front_value = empty ? '0 : front_q;
	assign res.back_value  = empty ? '0 : back_q;
	assign res.item_count  = ITEM_W'(count_q);
	assign res.is_empty    = empty;

endmodule
`default_nettype wire

@@ design/bounded_deque.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque
// Double-ended queue of signed 32-bit values in a circular store.
// ----------------------------------------------------------------------------
// Each command beat (push front, push back, pop front, pop back, query) gives
// one result beat with status, front and back elements, count and empty flag.
// A push when full and a pop when empty leave the deque unchanged and are
// flagged in status. A command occupies the block until its result beat is
// taken: the pointers are updated and the store written, then the front and
// back slots get a registered two-port read, then the result beat is shown.
// The next command is taken in the cycle after its result beat is taken.
module bounded_deque
	import bd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_stall,
	input  wire cmd_t cmd,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res
);

	dp_ctrl_t ctrl;

	bd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.ctrl      (ctrl)
	);

	bd_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.cmd    (cmd),
		.res    (res)
	);

endmodule
`default_nettype wire

@@ design/bd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bd_checker
// Port-level checks for the bounded deque, bound to the top level.
// ----------------------------------------------------------------------------
module bd_checker
	import bd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire logic cmd_stall,
	input wire logic res_valid,
	input wire logic res_stall,
	input wire res_t res
);

	// held result beat stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result beat changed while stalled");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.is_empty == (res.item_count == '0)))
		else $error("empty flag disagrees with count");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.is_empty |-> res.front_value == '0 && res.back_value == '0)
		else $error("empty deque shows nonzero ends");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.item_count <= ITEM_W'(DEPTH))
		else $error("count above capacity");

	// an accepted command blocks the next one and delays its result
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall && !res_valid)
		else $error("command accepted while busy");

endmodule

bind bounded_deque bd_checker u_bd_checker (.*);
`default_nettype wire
